/* hdl/four_channel_sound_generator_macros.svh */
// ----------------------------------------------------------------------------
// Sound generator assertion macros
// Shared concurrent assertion forms for the sound generator RTL.
// ----------------------------------------------------------------------------
`ifndef FOUR_CHANNEL_SOUND_GENERATOR_MACROS_SVH
`define FOUR_CHANNEL_SOUND_GENERATOR_MACROS_SVH
`ifndef SYNTH
`define FCSG_ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define FCSG_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define FCSG_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define FCSG_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

/* hdl/fcsg_pkg.sv */
// ----------------------------------------------------------------------------
// Sound generator package
// Types, register offsets and lookup tables of the sound generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package fcsg_pkg;

	typedef struct packed {
		logic       start;
		logic [3:0] vol;
		logic [3:0] cnt;
	} env_t;

	localparam logic       REQ_WRITE = 1'b0;
	localparam logic       REQ_TICK  = 1'b1;

	localparam logic [4:0] ADDR_P0_CTRL  = 5'd0;
	localparam logic [4:0] ADDR_P0_SWEEP = 5'd1;
	localparam logic [4:0] ADDR_P0_LO    = 5'd2;
	localparam logic [4:0] ADDR_P0_HI    = 5'd3;
	localparam logic [4:0] ADDR_P1_CTRL  = 5'd4;
	localparam logic [4:0] ADDR_P1_SWEEP = 5'd5;
	localparam logic [4:0] ADDR_P1_LO    = 5'd6;
	localparam logic [4:0] ADDR_P1_HI    = 5'd7;
	localparam logic [4:0] ADDR_TRI_CTRL = 5'd8;
	localparam logic [4:0] ADDR_TRI_LO   = 5'd10;
	localparam logic [4:0] ADDR_TRI_HI   = 5'd11;
	localparam logic [4:0] ADDR_NOI_CTRL = 5'd12;
	localparam logic [4:0] ADDR_NOI_MODE = 5'd14;
	localparam logic [4:0] ADDR_NOI_LEN  = 5'd15;
	localparam logic [4:0] ADDR_ENABLE   = 5'd21;
	localparam logic [4:0] ADDR_FRAME    = 5'd23;

	localparam logic [3:0] CFG_PAL       = 4'd0;
	localparam logic [3:0] CFG_FIRST     = 4'd1;
	localparam logic [3:0] CFG_SECOND    = 4'd2;
	localparam logic [3:0] CFG_THIRD     = 4'd3;
	localparam logic [3:0] CFG_LAST_FOUR = 4'd4;
	localparam logic [3:0] CFG_WRAP_FOUR = 4'd5;
	localparam logic [3:0] CFG_LAST_FIVE = 4'd6;
	localparam logic [3:0] CFG_WRAP_FIVE = 4'd7;

	localparam logic [10:0] PERIOD_MASK = 11'h7FF;
	localparam logic [3:0]  MAX_VOL     = 4'd15;

	function automatic logic [7:0] length_lut(input logic [4:0] i);
		logic [7:0] r;
		unique case (i)
			5'd0:  r = 8'd10;  5'd1:  r = 8'd254; 5'd2:  r = 8'd20;  5'd3:  r = 8'd2;
			5'd4:  r = 8'd40;  5'd5:  r = 8'd4;   5'd6:  r = 8'd80;  5'd7:  r = 8'd6;
			5'd8:  r = 8'd160; 5'd9:  r = 8'd8;   5'd10: r = 8'd60;  5'd11: r = 8'd10;
			5'd12: r = 8'd14;  5'd13: r = 8'd12;  5'd14: r = 8'd26;  5'd15: r = 8'd14;
			5'd16: r = 8'd12;  5'd17: r = 8'd16;  5'd18: r = 8'd24;  5'd19: r = 8'd18;
			5'd20: r = 8'd48;  5'd21: r = 8'd20;  5'd22: r = 8'd96;  5'd23: r = 8'd22;
			5'd24: r = 8'd192; 5'd25: r = 8'd24;  5'd26: r = 8'd72;  5'd27: r = 8'd26;
			5'd28: r = 8'd16;  5'd29: r = 8'd28;  5'd30: r = 8'd32;  default: r = 8'd30;
		endcase
		return r;
	endfunction

	function automatic logic [11:0] noise_lut(input logic pal, input logic [3:0] i);
		logic [11:0] n;
		logic [11:0] p;
		unique case (i)
			4'd0:  begin n = 12'd4;    p = 12'd4;    end
			4'd1:  begin n = 12'd8;    p = 12'd8;    end
			4'd2:  begin n = 12'd16;   p = 12'd14;   end
			4'd3:  begin n = 12'd32;   p = 12'd30;   end
			4'd4:  begin n = 12'd64;   p = 12'd60;   end
			4'd5:  begin n = 12'd96;   p = 12'd88;   end
			4'd6:  begin n = 12'd128;  p = 12'd118;  end
			4'd7:  begin n = 12'd160;  p = 12'd148;  end
			4'd8:  begin n = 12'd202;  p = 12'd188;  end
			4'd9:  begin n = 12'd254;  p = 12'd236;  end
			4'd10: begin n = 12'd380;  p = 12'd354;  end
			4'd11: begin n = 12'd508;  p = 12'd472;  end
			4'd12: begin n = 12'd762;  p = 12'd708;  end
			4'd13: begin n = 12'd1016; p = 12'd944;  end
			4'd14: begin n = 12'd2034; p = 12'd1890; end
			default: begin n = 12'd4068; p = 12'd3778; end
		endcase
		return pal ? p : n;
	endfunction

	function automatic logic duty_bit(input logic [1:0] duty, input logic [2:0] stp);
		logic [7:0] pat;
		unique case (duty)
			2'd0:    pat = 8'h02;
			2'd1:    pat = 8'h06;
			2'd2:    pat = 8'h1E;
			default: pat = 8'hF9;
		endcase
		return pat[stp];
	endfunction

	function automatic logic [3:0] tri_lut(input logic [4:0] stp);
		return stp[4] ? stp[3:0] : ~stp[3:0];
	endfunction

	function automatic env_t env_clock(input env_t e, input logic [3:0] period,
		input logic loop_en);
		env_t r;
		r = e;
		if (e.start) begin
			r.start = 1'b0;
			r.vol = MAX_VOL;
			r.cnt = period;
		end else if (e.cnt != 4'd0) begin
			r.cnt = e.cnt - 4'd1;
		end else begin
			r.cnt = period;
			if (e.vol != 4'd0) r.vol = e.vol - 4'd1;
			else if (loop_en) r.vol = MAX_VOL;
		end
		return r;
	endfunction

endpackage

/* hdl/four_channel_sound_generator.sv */
// ----------------------------------------------------------------------------
// Four-channel sound generator
// Two pulse, one triangle and one noise channel with a frame sequencer.
// ----------------------------------------------------------------------------
// Channel   Direction  Content
// s_*       in         register write or CPU-cycle tick
// m_*       out        four channel levels after the transaction
// cfg_*     in         frame sequencer step counts and timing select
//
// Every accepted transaction updates all state and registers its result,
// so one transaction is taken per cycle while m_tready is high. The result
// appears in the cycle after acceptance; the output register is the
// only stage, so s_tready falls only while a result waits on m_tready.
// Reset restores all state at once; cfg_ready is always high.
`timescale 1ns / 1ps
module four_channel_sound_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // reg_addr[4:0], write_data[12:5], cycle_parity[13]
	input  logic        s_tuser,  // req_type[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // pulse_one_level[3:0], pulse_two_level[7:4],
	                              // triangle_level[11:8], noise_level[15:12]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import fcsg_pkg::*;
	`include "four_channel_sound_generator_macros.svh"

	logic        pal_q;
	logic [15:0] first_q, second_q, third_q, last4_q, wrap4_q, last5_q, wrap5_q;

	logic [1:0]  duty_q [2];
	logic        halt_q [2], const_q [2], sw_en_q [2], sw_neg_q [2], sw_rel_q [2];
	logic [3:0]  vol_q [2];
	logic [2:0]  sw_per_q [2], sw_shift_q [2], sw_cnt_q [2], dstep_q [2];
	logic [10:0] per_q [2], div_q [2];
	logic [7:0]  len_q [2];
	env_t        env_q [2];
	logic [3:0]  en_q;
	logic        tctl_q, trel_q;
	logic [6:0]  tload_q, tcnt_q;
	logic [10:0] tper_q, tdiv_q;
	logic [7:0]  tlen_q;
	logic [4:0]  tstep_q;
	logic        nhalt_q, nconst_q, nmode_q;
	logic [3:0]  nvol_q, nidx_q;
	logic [11:0] ndiv_q;
	logic [7:0]  nlen_q;
	env_t        nenv_q;
	logic [14:0] lfsr_q;
	logic        mode_q;
	logic [15:0] cnt_q;

	logic [1:0]  duty_n [2];
	logic        halt_n [2], const_n [2], sw_en_n [2], sw_neg_n [2], sw_rel_n [2];
	logic [3:0]  vol_n [2];
	logic [2:0]  sw_per_n [2], sw_shift_n [2], sw_cnt_n [2], dstep_n [2];
	logic [10:0] per_n [2], div_n [2];
	logic [7:0]  len_n [2];
	env_t        env_n [2];
	logic [3:0]  en_n;
	logic        tctl_n, trel_n;
	logic [6:0]  tload_n, tcnt_n;
	logic [10:0] tper_n, tdiv_n;
	logic [7:0]  tlen_n;
	logic [4:0]  tstep_n;
	logic        nhalt_n, nconst_n, nmode_n;
	logic [3:0]  nvol_n, nidx_n;
	logic [11:0] ndiv_n;
	logic [7:0]  nlen_n;
	env_t        nenv_n;
	logic [14:0] lfsr_n;
	logic        mode_n;
	logic [15:0] cnt_n, cnt_inc, last_sel, wrap_sel;
	logic        qclk, hclk, fb;

	logic [15:0] tgt_q [2], tgt_n [2];
	logic        mute_q [2], mute_n [2];
	logic [3:0]  lv [2];
	logic [3:0]  tri_lv, noi_lv;

	logic        s_acc, m_valid_q;
	logic [15:0] m_data_q;
	logic        req_tick, parity;
	logic [4:0]  addr;
	logic [7:0]  wd;

	assign req_tick  = s_tuser;
	assign addr      = s_tdata[4:0];
	assign wd        = s_tdata[12:5];
	assign parity    = s_tdata[13];
	assign s_tready  = !m_valid_q || m_tready;
	assign s_acc     = s_tvalid && s_tready;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_q    <= 1'b0;
			first_q  <= 16'd7457;
			second_q <= 16'd14913;
			third_q  <= 16'd22371;
			last4_q  <= 16'd29829;
			wrap4_q  <= 16'd29830;
			last5_q  <= 16'd37281;
			wrap5_q  <= 16'd37282;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PAL:       pal_q    <= cfg_data[0];
				CFG_FIRST:     first_q  <= cfg_data;
				CFG_SECOND:    second_q <= cfg_data;
				CFG_THIRD:     third_q  <= cfg_data;
				CFG_LAST_FOUR: last4_q  <= cfg_data;
				CFG_WRAP_FOUR: wrap4_q  <= cfg_data;
				CFG_LAST_FIVE: last5_q  <= cfg_data;
				CFG_WRAP_FIVE: wrap5_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			tgt_q[c] = sw_neg_q[c]
				? 16'({5'd0, per_q[c]} - {5'd0, per_q[c] >> sw_shift_q[c]} - 16'(c == 0))
				: 16'({5'd0, per_q[c]} + {5'd0, per_q[c] >> sw_shift_q[c]});
			mute_q[c] = (per_q[c] < 11'd8) || (tgt_q[c] > {5'd0, PERIOD_MASK});
		end
	end

	always_comb begin
		duty_n = duty_q; halt_n = halt_q; const_n = const_q; vol_n = vol_q;
		sw_en_n = sw_en_q; sw_neg_n = sw_neg_q; sw_rel_n = sw_rel_q;
		sw_per_n = sw_per_q; sw_shift_n = sw_shift_q; sw_cnt_n = sw_cnt_q;
		dstep_n = dstep_q; per_n = per_q; div_n = div_q; len_n = len_q; env_n = env_q;
		en_n = en_q; tctl_n = tctl_q; trel_n = trel_q; tload_n = tload_q;
		tcnt_n = tcnt_q; tper_n = tper_q; tdiv_n = tdiv_q; tlen_n = tlen_q;
		tstep_n = tstep_q; nhalt_n = nhalt_q; nconst_n = nconst_q; nmode_n = nmode_q;
		nvol_n = nvol_q; nidx_n = nidx_q; ndiv_n = ndiv_q; nlen_n = nlen_q;
		nenv_n = nenv_q; lfsr_n = lfsr_q; mode_n = mode_q; cnt_n = cnt_q;
		qclk = 1'b0;
		hclk = 1'b0;
		fb = lfsr_q[0] ^ (nmode_q ? lfsr_q[6] : lfsr_q[1]);
		cnt_inc  = cnt_q + 16'd1;
		last_sel = mode_q ? last5_q : last4_q;
		wrap_sel = mode_q ? wrap5_q : wrap4_q;
		if (req_tick == REQ_TICK) begin
			if (parity) begin
				for (int c = 0; c < 2; c++) begin
					if (div_q[c] != 11'd0) begin
						div_n[c] = div_q[c] - 11'd1;
					end else begin
						div_n[c] = per_q[c];
						dstep_n[c] = dstep_q[c] + 3'd1;
					end
				end
			end
			if (tdiv_q != 11'd0) begin
				tdiv_n = tdiv_q - 11'd1;
			end else begin
				tdiv_n = tper_q;
				if (tlen_q != 8'd0 && tcnt_q != 7'd0) tstep_n = tstep_q + 5'd1;
			end
			if (ndiv_q != 12'd0) begin
				ndiv_n = ndiv_q - 12'd1;
			end else begin
				ndiv_n = noise_lut(pal_q, nidx_q);
				lfsr_n = {fb, lfsr_q[14:1]};
			end
			cnt_n = cnt_inc;
			priority if (cnt_inc == first_q) begin
				qclk = 1'b1;
			end else if (cnt_inc == second_q) begin
				qclk = 1'b1;
				hclk = 1'b1;
			end else if (cnt_inc == third_q) begin
				qclk = 1'b1;
			end else if (cnt_inc == last_sel) begin
				qclk = 1'b1;
				hclk = 1'b1;
			end else if (cnt_inc >= wrap_sel) begin
				cnt_n = 16'd0;
			end
		end else begin
			unique case (addr)
				ADDR_P0_CTRL, ADDR_P1_CTRL: begin
					duty_n[addr[2]]  = wd[7:6];
					halt_n[addr[2]]  = wd[5];
					const_n[addr[2]] = wd[4];
					vol_n[addr[2]]   = wd[3:0];
				end
				ADDR_P0_SWEEP, ADDR_P1_SWEEP: begin
					sw_en_n[addr[2]]    = wd[7];
					sw_per_n[addr[2]]   = wd[6:4];
					sw_neg_n[addr[2]]   = wd[3];
					sw_shift_n[addr[2]] = wd[2:0];
					sw_rel_n[addr[2]]   = 1'b1;
				end
				ADDR_P0_LO, ADDR_P1_LO: begin
					per_n[addr[2]] = {per_q[addr[2]][10:8], wd};
				end
				ADDR_P0_HI, ADDR_P1_HI: begin
					per_n[addr[2]] = {wd[2:0], per_q[addr[2]][7:0]};
					if (en_q[addr[2]]) len_n[addr[2]] = length_lut(wd[7:3]);
					env_n[addr[2]].start = 1'b1;
					dstep_n[addr[2]] = 3'd0;
				end
				ADDR_TRI_CTRL: begin
					tctl_n  = wd[7];
					tload_n = wd[6:0];
				end
				ADDR_TRI_LO: tper_n = {tper_q[10:8], wd};
				ADDR_TRI_HI: begin
					tper_n = {wd[2:0], tper_q[7:0]};
					if (en_q[2]) tlen_n = length_lut(wd[7:3]);
					trel_n = 1'b1;
				end
				ADDR_NOI_CTRL: begin
					nhalt_n  = wd[5];
					nconst_n = wd[4];
					nvol_n   = wd[3:0];
				end
				ADDR_NOI_MODE: begin
					nmode_n = wd[7];
					nidx_n  = wd[3:0];
				end
				ADDR_NOI_LEN: begin
					if (en_q[3]) nlen_n = length_lut(wd[7:3]);
					nenv_n.start = 1'b1;
				end
				ADDR_ENABLE: begin
					en_n = wd[3:0];
					if (!wd[0]) len_n[0] = 8'd0;
					if (!wd[1]) len_n[1] = 8'd0;
					if (!wd[2]) tlen_n = 8'd0;
					if (!wd[3]) nlen_n = 8'd0;
				end
				ADDR_FRAME: begin
					mode_n = wd[7];
					cnt_n = 16'd0;
					qclk = wd[7];
					hclk = wd[7];
				end
				default: ;
			endcase
		end
		if (qclk) begin
			for (int c = 0; c < 2; c++) env_n[c] = env_clock(env_q[c], vol_q[c], halt_q[c]);
			nenv_n = env_clock(nenv_q, nvol_q, nhalt_q);
			if (trel_q) tcnt_n = tload_q;
			else if (tcnt_q != 7'd0) tcnt_n = tcnt_q - 7'd1;
			if (!tctl_q) trel_n = 1'b0;
		end
		if (hclk) begin
			for (int c = 0; c < 2; c++) begin
				if (!halt_q[c] && len_q[c] != 8'd0) len_n[c] = len_q[c] - 8'd1;
				if (sw_rel_q[c]) begin
					sw_cnt_n[c] = sw_per_q[c];
					if (sw_en_q[c] && sw_cnt_q[c] == 3'd0 && !mute_q[c])
						per_n[c] = tgt_q[c][10:0];
					sw_rel_n[c] = 1'b0;
				end else if (sw_cnt_q[c] != 3'd0) begin
					sw_cnt_n[c] = sw_cnt_q[c] - 3'd1;
				end else begin
					sw_cnt_n[c] = sw_per_q[c];
					if (sw_en_q[c] && !mute_q[c]) per_n[c] = tgt_q[c][10:0];
				end
			end
			if (!tctl_q && tlen_q != 8'd0) tlen_n = tlen_q - 8'd1;
			if (!nhalt_q && nlen_q != 8'd0) nlen_n = nlen_q - 8'd1;
		end
	end

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			tgt_n[c] = sw_neg_n[c]
				? 16'({5'd0, per_n[c]} - {5'd0, per_n[c] >> sw_shift_n[c]} - 16'(c == 0))
				: 16'({5'd0, per_n[c]} + {5'd0, per_n[c] >> sw_shift_n[c]});
			mute_n[c] = (per_n[c] < 11'd8) || (tgt_n[c] > {5'd0, PERIOD_MASK});
			lv[c] = 4'd0;
			if (len_n[c] != 8'd0 && !mute_n[c] && duty_bit(duty_n[c], dstep_n[c]))
				lv[c] = const_n[c] ? vol_n[c] : env_n[c].vol;
		end
		tri_lv = (tlen_n != 8'd0 && tcnt_n != 7'd0 && tper_n >= 11'd2)
			? tri_lut(tstep_n) : 4'd0;
		noi_lv = (nlen_n != 8'd0 && !lfsr_n[0]) ? (nconst_n ? nvol_n : nenv_n.vol) : 4'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 2; c++) begin
				duty_q[c] <= '0; halt_q[c] <= 1'b0; const_q[c] <= 1'b0; vol_q[c] <= '0;
				sw_en_q[c] <= 1'b0; sw_neg_q[c] <= 1'b0; sw_rel_q[c] <= 1'b0;
				sw_per_q[c] <= '0; sw_shift_q[c] <= '0; sw_cnt_q[c] <= '0;
				dstep_q[c] <= '0; per_q[c] <= '0; div_q[c] <= '0; len_q[c] <= '0;
				env_q[c] <= '0;
			end
			en_q <= '0; tctl_q <= 1'b0; trel_q <= 1'b0; tload_q <= '0; tcnt_q <= '0;
			tper_q <= '0; tdiv_q <= '0; tlen_q <= '0; tstep_q <= '0;
			nhalt_q <= 1'b0; nconst_q <= 1'b0; nmode_q <= 1'b0; nvol_q <= '0;
			nidx_q <= '0; ndiv_q <= '0; nlen_q <= '0; nenv_q <= '0;
			lfsr_q <= 15'd1; mode_q <= 1'b0; cnt_q <= '0;
			m_valid_q <= 1'b0;
			m_data_q <= '0;
		end else begin
			if (s_acc) begin
				duty_q <= duty_n; halt_q <= halt_n; const_q <= const_n; vol_q <= vol_n;
				sw_en_q <= sw_en_n; sw_neg_q <= sw_neg_n; sw_rel_q <= sw_rel_n;
				sw_per_q <= sw_per_n; sw_shift_q <= sw_shift_n; sw_cnt_q <= sw_cnt_n;
				dstep_q <= dstep_n; per_q <= per_n; div_q <= div_n; len_q <= len_n;
				env_q <= env_n;
				en_q <= en_n; tctl_q <= tctl_n; trel_q <= trel_n; tload_q <= tload_n;
				tcnt_q <= tcnt_n; tper_q <= tper_n; tdiv_q <= tdiv_n; tlen_q <= tlen_n;
				tstep_q <= tstep_n; nhalt_q <= nhalt_n; nconst_q <= nconst_n;
				nmode_q <= nmode_n; nvol_q <= nvol_n; nidx_q <= nidx_n;
				ndiv_q <= ndiv_n; nlen_q <= nlen_n; nenv_q <= nenv_n;
				lfsr_q <= lfsr_n; mode_q <= mode_n; cnt_q <= cnt_n;
				m_data_q <= {noi_lv, tri_lv, lv[1], lv[0]};
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	`FCSG_ASSERT_NEXT(a_acc_gives_result, clk, arst_n, s_acc, m_valid_q)
	`FCSG_ASSERT_IMPLY(a_lfsr_nonzero, clk, arst_n, 1'b1, lfsr_q != 15'd0)
	`FCSG_ASSERT_IMPLY(a_stall_only_when_full, clk, arst_n, !s_tready, m_valid_q && !m_tready)
	`FCSG_ASSERT_NEXT(a_tick_counts, clk, arst_n, s_acc && req_tick == REQ_TICK && !qclk,
		cnt_q == 16'd0 || cnt_q == $past(cnt_q) + 16'd1)

endmodule
